FILE: design/phh_pkg.sv
// Shared package for the pulse-height histogram block.
// Holds field widths, register and opcode codes, controller state and control structs.
// No dependencies.
package phh_pkg;

  // Fixed field widths
  localparam int unsigned AMP_W    = 12;
  localparam int unsigned BIN_W    = 12;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_A_W  = 4;

  // Defaults for the top-level parameters
  localparam int unsigned BIN_SLOTS_DEF  = 4096;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_ENABLE = 4'd0,
    REG_MODE   = 4'd1,
    REG_OFFSET = 4'd2,
    REG_LIMIT  = 4'd3
  } cfg_reg_t;

  // Item opcodes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Resolution modes (mode 3 behaves as 1024 bins)
  localparam logic [MODE_W-1:0] MODE_1K = 2'd0;
  localparam logic [MODE_W-1:0] MODE_2K = 2'd1;
  localparam logic [MODE_W-1:0] MODE_4K = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } phh_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear_we;  // write zero at the sweep address
    logic load;      // capture the accepted item
    logic commit;    // write back, bump pulse count, load result
  } phh_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_last;  // sweep is at the last slot
    logic out_free;    // result register can take a new result
  } phh_status_t;

endpackage

FILE: design/phh_if.sv
// Channel interfaces for the pulse-height histogram block.
// Depends on phh_pkg for field widths.

interface phh_in_if import phh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [AMP_W-1:0] amplitude;
  logic [BIN_W-1:0] read_bin;

  modport source (output valid, opcode, amplitude, read_bin, input ready);
  modport sink   (input valid, opcode, amplitude, read_bin, output ready);
endinterface

interface phh_out_if import phh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BIN_W-1:0]  bin_index;
  logic [WORD_W-1:0] bin_count;
  logic [WORD_W-1:0] pulse_total;
  logic              counted;

  modport source (output valid, bin_index, bin_count, pulse_total, counted, input ready);
  modport sink   (input valid, bin_index, bin_count, pulse_total, counted, output ready);
endinterface

interface phh_cfg_if import phh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] addr;
  logic [WORD_W-1:0]  wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

FILE: design/phh_ctrl.sv
// Controller state machine for the pulse-height histogram block.
// Depends on phh_pkg for state and command/status types.
module phh_ctrl import phh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  phh_status_t status,
  output phh_cmd_t    cmd
);

  phh_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: design/phh_datapath.sv
// Datapath for the pulse-height histogram: config registers, bin selection,
// bin count memory, pulse counter and result register. Depends on phh_pkg.
module phh_datapath import phh_pkg::*; #(
  parameter int unsigned BIN_SLOTS  = BIN_SLOTS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // item fields
  input  logic               in_opcode,
  input  logic [AMP_W-1:0]   in_amplitude,
  input  logic [BIN_W-1:0]   in_read_bin,
  // config writes
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]  cfg_wdata,
  // result
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BIN_W-1:0]   out_bin_index,
  output logic [WORD_W-1:0]  out_bin_count,
  output logic [WORD_W-1:0]  out_pulse_total,
  output logic               out_counted,
  // control
  input  phh_cmd_t           cmd,
  output phh_status_t        status
);

  localparam int unsigned SLOT_W = $clog2(BIN_SLOTS);
  localparam int unsigned RED_W  = BIN_W + 2;
  localparam logic [RED_W-1:0]  SLOTS_X1 = RED_W'(BIN_SLOTS);
  localparam logic [RED_W-1:0]  SLOTS_X2 = RED_W'(2 * BIN_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BIN_SLOTS - 1);

  // Config registers
  logic              enable_r;
  logic [MODE_W-1:0] mode_r;
  logic [AMP_W-1:0]  offset_r;
  logic [WORD_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      mode_r   <= MODE_1K;
      offset_r <= '0;
      limit_r  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENABLE: enable_r <= cfg_wdata[0];
        REG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_OFFSET: offset_r <= cfg_wdata[AMP_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Bin selection
  logic [AMP_W:0]     level_sum;
  logic [BIN_W-1:0]   raw_bin;
  logic [RED_W-1:0]   red1, red2;
  logic [SLOT_W-1:0]  slot;

  always_comb begin
    level_sum = {1'b0, in_amplitude} + {1'b0, offset_r};
    if (in_opcode == OP_READ) begin
      raw_bin = in_read_bin;
    end else begin
      unique case (mode_r)
        MODE_2K: raw_bin = {1'b0, level_sum[BIN_W-1:1]};
        MODE_4K: raw_bin = level_sum[BIN_W-1:0];
        default: raw_bin = {2'b00, level_sum[BIN_W-1:2]};
      endcase
    end
    // wrap into the store: raw_bin < 4 * BIN_SLOTS
    red1 = {2'b00, raw_bin};
    if (red1 >= SLOTS_X2) begin
      red1 = red1 - SLOTS_X2;
    end
    red2 = red1;
    if (red2 >= SLOTS_X1) begin
      red2 = red2 - SLOTS_X1;
    end
    slot = red2[SLOT_W-1:0];
  end

  // Item registers
  logic [SLOT_W-1:0] slot_r;
  logic              record_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r   <= slot;
      record_r <= (in_opcode == OP_RECORD);
    end
  end

  // Clearing sweep
  logic [SLOT_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_we) begin
      clr_addr_r <= clr_addr_r + SLOT_W'(1);
    end
  end

  // Bin count memory
  logic [COUNT_BITS-1:0] bin_mem [BIN_SLOTS];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  take;
  logic                  bump;
  logic [COUNT_BITS-1:0] cnt_new;

  assign take    = record_r & enable_r;
  assign bump    = take && (WORD_W'(rd_data_r) < limit_r) && !(&rd_data_r);
  assign cnt_new = bump ? rd_data_r + COUNT_BITS'(1) : rd_data_r;

  assign mem_we    = cmd.clear_we | (cmd.commit & bump);
  assign mem_waddr = cmd.clear_we ? clr_addr_r : slot_r;
  assign mem_wdata = cmd.clear_we ? '0 : cnt_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= bin_mem[slot_r];
  end

  // Pulse counter
  logic [WORD_W-1:0] pulses_r;
  logic [WORD_W-1:0] pulses_nxt;

  assign pulses_nxt = take ? pulses_r + WORD_W'(1) : pulses_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulses_r <= '0;
    end else if (cmd.commit) begin
      pulses_r <= pulses_nxt;
    end
  end

  // Result register
  logic              out_valid_r;
  logic [BIN_W-1:0]  out_bin_r;
  logic [WORD_W-1:0] out_count_r;
  logic [WORD_W-1:0] out_total_r;
  logic              out_counted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_bin_r     <= BIN_W'(slot_r);
      out_count_r   <= WORD_W'(cnt_new);
      out_total_r   <= pulses_nxt;
      out_counted_r <= take;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_index   = out_bin_r;
  assign out_bin_count   = out_count_r;
  assign out_pulse_total = out_total_r;
  assign out_counted     = out_counted_r;

  assign status.clear_last = (clr_addr_r == SLOT_LAST);
  assign status.out_free   = !out_valid_r || out_ready;

endmodule

FILE: design/pulse_height_histogram.sv
// Pulse-height histogram top level: one item at a time, in the steps accept, memory read,
// write back; the result register is loaded in the write-back cycle, so a result shows
// once its write-back is done and waits there if the sink stalls.
// The item rate is set by the read-modify-write through the registered memory read.
// After rst_n a clearing pass zeroes all BIN_SLOTS counts, one per cycle; no item is
// taken meanwhile, config writes are taken at any time.
module pulse_height_histogram import phh_pkg::*; #(
  parameter int unsigned BIN_SLOTS  = BIN_SLOTS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  phh_in_if.sink    in_ch,
  phh_out_if.source out_ch,
  phh_cfg_if.sink   cfg_ch
);

  phh_cmd_t    cmd;
  phh_status_t status;

  // Config registers take a write in any cycle.
  assign cfg_ch.ready = 1'b1;

  // Sequencer: clear sweep, then idle / read / write-back per item.
  phh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Bin selection, count memory, pulse counter and result register.
  phh_datapath #(
    .BIN_SLOTS  (BIN_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_ch.opcode),
    .in_amplitude    (in_ch.amplitude),
    .in_read_bin     (in_ch.read_bin),
    .cfg_we          (cfg_ch.valid),
    .cfg_addr        (cfg_ch.addr),
    .cfg_wdata       (cfg_ch.wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_bin_index   (out_ch.bin_index),
    .out_bin_count   (out_ch.bin_count),
    .out_pulse_total (out_ch.pulse_total),
    .out_counted     (out_ch.counted),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

FILE: design/phh_checker.sv
// Port-level checks for the pulse-height histogram, bound to the top level.
// Depends on phh_pkg for field widths.
module phh_checker import phh_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_bin_count,
  input logic              out_counted
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // The clearing pass blocks items right after reset.
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("item taken during clearing pass");

  // One item at a time: no transfer in the cycle after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken while an item is in flight");

  // A result appears once write-back finds the result register free.
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer ##2 (!out_valid || out_ready)) |=> out_valid)
    else $error("result missing after write-back");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_count)
      && $stable(out_counted))
    else $error("stalled result changed");

endmodule

bind pulse_height_histogram phh_checker u_phh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_bin_count (out_ch.bin_count),
  .out_counted   (out_ch.counted)
);

FILE: verif/tb.sv
// Self-checking testbench for the pulse-height histogram block (pulse_height_histogram).
// Depends on phh_pkg and the channel interfaces in phh_if; keeps its own spectrum model
// and compares each result transfer against it.
module tb;
  import phh_pkg::*;

  // Geometry of the instance under test (package defaults)
  localparam int unsigned NUM_BINS    = BIN_SLOTS_DEF;
  localparam logic [WORD_W-1:0] COUNT_MAX = WORD_W'((64'd1 << COUNT_BITS_DEF) - 64'd1);

  // Mode 3 has no package name; it aliases the 1024-bin mode
  localparam logic [MODE_W-1:0] MODE_ALIAS_1K = 2'd3;

  // Register indexes past the last defined one are ignored by the block
  localparam logic [CFG_A_W-1:0] FIRST_UNUSED_REG = REG_LIMIT + 1'b1;
  localparam logic [CFG_A_W-1:0] LAST_UNUSED_REG  = '1;

  localparam logic [AMP_W-1:0] AMP_MAX = '1;

  // Cycles the block may still be busy after its last result (accept, read, write back)
  localparam int unsigned SETTLE_CYCLES = 6;
  // Clearing pass plus ~925 items at worst-case gaps and stalls, taken several times over
  localparam int unsigned CYCLE_LIMIT = 300000;

  localparam int unsigned RANDOM_PHASES   = 12;
  localparam int unsigned ITEMS_PER_PHASE = 75;

  typedef struct packed {
    logic [BIN_W-1:0]  bin_index;
    logic [WORD_W-1:0] bin_count;
    logic [WORD_W-1:0] pulse_total;
    logic              counted;
  } bin_report_t;

  logic clk = 1'b0;
  logic rst_n;

  phh_in_if  in_if ();
  phh_out_if out_if ();
  phh_cfg_if cfg_if ();

  pulse_height_histogram dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Spectrum model: bins, pulse counter and register shadow
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] spectrum [NUM_BINS];
  logic [WORD_W-1:0] pulse_count;
  logic              shadow_enable;
  logic [MODE_W-1:0] shadow_mode;
  logic [AMP_W-1:0]  shadow_offset;
  logic [WORD_W-1:0] shadow_limit;
  logic [BIN_W-1:0]  last_slot;   // most recent bin touched, steers reads

  bin_report_t pending_reports [$];

  int unsigned record_items;
  int unsigned read_items;
  int unsigned reports_checked;
  int unsigned reg_writes;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          bursts_on;       // random idling on both channels

  function automatic void reset_spectrum();
    foreach (spectrum[i]) spectrum[i] = '0;
    pulse_count   = '0;
    shadow_enable = 1'b0;
    shadow_mode   = MODE_1K;
    shadow_offset = '0;
    shadow_limit  = '1;
    last_slot     = '0;
  endfunction

  function automatic void shadow_reg_write(input logic [CFG_A_W-1:0] index,
                                           input logic [WORD_W-1:0] data);
    case (index)
      REG_ENABLE: shadow_enable = data[0];
      REG_MODE:   shadow_mode   = data[MODE_W-1:0];
      REG_OFFSET: shadow_offset = data[AMP_W-1:0];
      REG_LIMIT:  shadow_limit  = data;
      default: ;  // unused index, no effect
    endcase
  endfunction

  // Works out the result of one accepted item and updates the spectrum
  function automatic bin_report_t tally_pulse(input logic op, input logic [AMP_W-1:0] amp,
                                              input logic [BIN_W-1:0] rbin);
    logic [AMP_W:0]   level_sum;
    logic [BIN_W-1:0] slot;
    bin_report_t      rep;
    rep.counted = 1'b0;
    if (op == OP_RECORD) begin
      level_sum = {1'b0, amp} + {1'b0, shadow_offset};
      case (shadow_mode)
        MODE_2K: slot = {1'b0, level_sum[11:1]};
        MODE_4K: slot = level_sum[11:0];
        default: slot = {2'b00, level_sum[11:2]};  // 1024 bins, alias mode too
      endcase
      slot = BIN_W'(slot % NUM_BINS);
      if (shadow_enable) begin
        pulse_count = pulse_count + 1'b1;
        rep.counted = 1'b1;
        // saturate at the limit and at the counter width
        if (spectrum[slot] < shadow_limit && spectrum[slot] < COUNT_MAX)
          spectrum[slot] = spectrum[slot] + 1'b1;
      end
    end else begin
      slot = BIN_W'(rbin % NUM_BINS);
    end
    rep.bin_index   = slot;
    rep.bin_count   = spectrum[slot];
    rep.pulse_total = pulse_count;
    last_slot       = slot;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. valid is left high between back-to-back transfers and only
  // dropped by a gap, drain_reports or the end of a register batch, so a signal
  // never sees two nonblocking updates in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [AMP_W-1:0] amp,
                           input logic [BIN_W-1:0] rbin);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.amplitude <= amp;
    in_if.read_bin  <= rbin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    // transfer accepted at this edge
    pending_reports.push_back(tally_pulse(op, amp, rbin));
    if (op == OP_RECORD) record_items++;
    else read_items++;
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] index, input logic [WORD_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= index;
    cfg_if.wdata <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    shadow_reg_write(index, data);
    reg_writes++;
  endtask

  task automatic set_reg(input logic [CFG_A_W-1:0] index, input logic [WORD_W-1:0] data);
    write_reg(index, data);
    cfg_if.valid <= 1'b0;
  endtask

  // Writes all four registers; with noise set, the bits above each field carry junk
  task automatic program_regs(input logic en, input logic [MODE_W-1:0] mode,
                              input logic [AMP_W-1:0] offset, input logic [WORD_W-1:0] limit,
                              input bit noise);
    logic [WORD_W-1:0] junk;
    junk = noise ? WORD_W'($urandom) : '0;
    write_reg(REG_ENABLE, {junk[WORD_W-1:1], en});
    write_reg(REG_MODE, {junk[WORD_W-1:MODE_W], mode});
    write_reg(REG_OFFSET, {junk[WORD_W-1:AMP_W], offset});
    write_reg(REG_LIMIT, limit);
    cfg_if.valid <= 1'b0;
  endtask

  // Block goes idle: every result in, then the pipeline's own depth
  task automatic drain_reports();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result sink: ready drops in bursts while bursts_on is set
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Result checker: each result transfer against the oldest pending report
  always @(posedge clk) begin : check_results
    bin_report_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: bin_index %0d bin_count %0d", out_if.bin_index,
               out_if.bin_count);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_if.bin_index !== want.bin_index) begin
          $error("bin_index: expected %0d, got %0d", want.bin_index, out_if.bin_index);
          mismatch_count++;
        end
        if (out_if.bin_count !== want.bin_count) begin
          $error("bin_count: expected %0d, got %0d", want.bin_count, out_if.bin_count);
          mismatch_count++;
        end
        if (out_if.pulse_total !== want.pulse_total) begin
          $error("pulse_total: expected %0d, got %0d", want.pulse_total, out_if.pulse_total);
          mismatch_count++;
        end
        if (out_if.counted !== want.counted) begin
          $error("counted: expected %0b, got %0b", want.counted, out_if.counted);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_reports.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: histogram disabled, so records only report the would-be bin.
  // These items wait out the clearing pass.
  task automatic test_disabled_after_reset();
    send_item(OP_RECORD, '0, '1);
    send_item(OP_RECORD, AMP_MAX, '0);
    send_item(OP_READ, '0, '1);
    send_item(OP_READ, AMP_MAX, '0);
    drain_reports();
  endtask

  // Every resolution mode at both amplitude extremes and the largest offset
  task automatic test_resolution_modes();
    logic [MODE_W-1:0] modes [4];
    modes = '{MODE_1K, MODE_2K, MODE_4K, MODE_ALIAS_1K};
    foreach (modes[m]) begin
      program_regs(1'b1, modes[m], '0, '1, 1'b0);
      send_item(OP_RECORD, '0, '0);
      send_item(OP_RECORD, AMP_MAX, '0);
      drain_reports();
      set_reg(REG_OFFSET, WORD_W'(AMP_MAX));   // sum carries into bit 12
      send_item(OP_RECORD, AMP_MAX, '0);
      drain_reports();
    end
  endtask

  // Saturation at a small limit, with back-to-back hits on one bin, then limit zero
  task automatic test_count_limit();
    program_regs(1'b1, MODE_4K, '0, 32'd2, 1'b0);
    repeat (4) send_item(OP_RECORD, 12'd100, '0);
    send_item(OP_READ, '0, 12'd100);
    drain_reports();
    set_reg(REG_LIMIT, '0);
    send_item(OP_RECORD, 12'd200, '0);
    send_item(OP_READ, '0, 12'd200);
    drain_reports();
  endtask

  // Writes to indexes past the register file change nothing
  task automatic test_unused_registers();
    write_reg(FIRST_UNUSED_REG, '0);
    write_reg(LAST_UNUSED_REG, WORD_W'($urandom));
    write_reg(CFG_A_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)), '1);
    cfg_if.valid <= 1'b0;
    send_item(OP_RECORD, 12'd100, '0);
    send_item(OP_READ, '0, 12'd100);
    drain_reports();
  endtask

  // Random phases: fresh settings each phase, then a mix that favors repeats on
  // one bin and a narrow hot range so small limits saturate; reads follow the
  // latest bin or land anywhere.
  task automatic test_random_traffic();
    logic [WORD_W-1:0] limit;
    logic [AMP_W-1:0]  offset;
    logic [AMP_W-1:0]  amp;
    logic [AMP_W-1:0]  prev_amp;
    logic [BIN_W-1:0]  rbin;
    logic [AMP_W-1:0]  hot_base;
    int unsigned       pick;
    prev_amp = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // quiet stretches now and then, none at all in the closing phases
      bursts_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0: limit = '1;
        1: limit = '0;
        2: limit = 32'd1;
        3: limit = WORD_W'($urandom_range(2, 6));
        default: limit = WORD_W'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0: offset = '0;
        1: offset = AMP_MAX;
        default: offset = AMP_W'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) set_reg(CFG_A_W'($urandom_range(FIRST_UNUSED_REG,
                                                                     LAST_UNUSED_REG)),
                                             WORD_W'($urandom));
      program_regs($urandom_range(0, 7) != 0, MODE_W'($urandom_range(0, 3)), offset, limit,
                   1'($urandom_range(0, 1)));
      hot_base = AMP_W'($urandom_range(0, AMP_MAX - 15));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        amp  = AMP_W'($urandom);
        rbin = BIN_W'($urandom);
        if (pick < 25) begin
          if (pick < 12) rbin = last_slot;
          send_item(OP_READ, amp, rbin);
        end else begin
          if (pick < 50) amp = prev_amp;
          else if (pick < 70) amp = hot_base + AMP_W'($urandom_range(0, 15));
          prev_amp = amp;
          send_item(OP_RECORD, amp, rbin);
        end
      end
      drain_reports();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= OP_RECORD;
    in_if.amplitude  <= '0;
    in_if.read_bin   <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.addr      <= REG_ENABLE;
    cfg_if.wdata     <= '0;
    record_items     = 0;
    read_items       = 0;
    reg_writes       = 0;
    bursts_on        = 1'b1;
    reset_spectrum();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_disabled_after_reset();
    test_resolution_modes();
    test_count_limit();
    test_unused_registers();
    test_random_traffic();

    $display("Checked %0d results from %0d records and %0d reads, %0d register writes.",
             reports_checked, record_items, read_items, reg_writes);
    $display("All modes, offset and limit extremes, saturation and disabled records covered.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
